// File: rtl/core/nested_block_profiler_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nested block profiler
// Immediate-cycle and next-cycle implication checks on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef NESTED_BLOCK_PROFILER_CORE_ASSERT_SVH
`define NESTED_BLOCK_PROFILER_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define NBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define NBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nbp_pkg.sv
// ----------------------------------------------------------------------------
// nbp_pkg
// Shared types and codes of the nested block profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package nbp_pkg;

  localparam int UNIT_COUNT = 4096;
  localparam int UNIT_W     = 12;

  localparam logic [1:0] KIND_ENTER = 2'd0;
  localparam logic [1:0] KIND_EXIT  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_STACK_FULL = 2'd1;
  localparam logic [1:0] ST_STACK_EMPT = 2'd2;
  localparam logic [1:0] ST_ROOT_ENTER = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [UNIT_W-1:0] unit_id;
    logic [63:0]       timestamp;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [UNIT_W-1:0] result_unit;
    logic [31:0]       hit_count;
    logic [63:0]       inclusive_time;
    logic [63:0]       exclusive_time;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [63:0] incl;
    logic [63:0] excl;
  } tbl_entry_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [63:0]       start;
    logic [63:0]       saved;
  } frame_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_TWAIT,
    S_XTOP,
    S_XPAR,
    S_XUPDPOP,
    S_XRDPAR,
    S_XUPDPAR,
    S_REPORT
  } state_t;

  typedef enum logic [1:0] {
    SEL_REQ,
    SEL_ZERO,
    SEL_POP,
    SEL_PAR
  } addr_sel_t;

  typedef struct packed {
    logic       clr_en;
    logic       load_req;
    logic       set_status;
    logic [1:0] status;
    logic       tbl_rd;
    addr_sel_t  tbl_sel;
    logic       cap_rep;
    logic       push;
    logic       stk_rd_top;
    logic       stk_rd_par;
    logic       cap_top;
    logic       cap_par;
    logic       wr_pop;
    logic       wr_par;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       unit_zero;
    logic       stack_full;
    logic       stack_empty;
    logic       clear_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/nbp_ctrl.sv
// ----------------------------------------------------------------------------
// nbp_ctrl
// Sequencer of the profiler: table clear, request decode, enter/read and
// exit read-modify-write steps, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module nbp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire nbp_pkg::sts_t sts,
  output nbp_pkg::cmd_t      cmd
);
  import nbp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:    if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (sts.kind == KIND_EXIT && !sts.stack_empty) state_nxt = S_XTOP;
        else state_nxt = S_TWAIT;
      end
      S_TWAIT:   state_nxt = S_REPORT;
      S_XTOP:    state_nxt = S_XPAR;
      S_XPAR:    state_nxt = S_XUPDPOP;
      S_XUPDPOP: state_nxt = S_XRDPAR;
      S_XRDPAR:  state_nxt = S_XUPDPAR;
      S_XUPDPAR: state_nxt = S_REPORT;
      S_REPORT:  if (sts.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.tbl_sel = SEL_REQ;
    case (state_r)
      S_CLEAR: cmd.clr_en = 1'b1;
      S_IDLE:  cmd.load_req = in_valid;
      S_DECODE: begin
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        cmd.tbl_rd     = 1'b1;
        if (sts.kind == KIND_ENTER) begin
          if (sts.unit_zero) begin
            cmd.status  = ST_ROOT_ENTER;
            cmd.tbl_sel = SEL_ZERO;
          end else if (sts.stack_full) begin
            cmd.status  = ST_STACK_FULL;
          end
        end else if (sts.kind == KIND_EXIT) begin
          if (sts.stack_empty) begin
            cmd.status  = ST_STACK_EMPT;
            cmd.tbl_sel = SEL_ZERO;
          end else begin
            cmd.tbl_rd     = 1'b0;
            cmd.stk_rd_top = 1'b1;
          end
        end
      end
      S_TWAIT: begin
        cmd.cap_rep = 1'b1;
        cmd.push    = (sts.kind == KIND_ENTER) && !sts.unit_zero && !sts.stack_full;
      end
      S_XTOP: begin
        cmd.cap_top    = 1'b1;
        cmd.stk_rd_par = 1'b1;
      end
      S_XPAR: begin
        cmd.cap_par = 1'b1;
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = SEL_POP;
      end
      S_XUPDPOP: cmd.wr_pop = 1'b1;
      S_XRDPAR: begin
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = SEL_PAR;
      end
      S_XUPDPAR: cmd.wr_par = 1'b1;
      S_REPORT:  cmd.load_out = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/nbp_dp.sv
// ----------------------------------------------------------------------------
// nbp_dp
// Datapath of the profiler: unit table, frame stack, elapsed-time
// arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nbp_dp #(
  parameter int NEST_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire nbp_pkg::in_req_t in_data,
  input  wire nbp_pkg::cmd_t    cmd,
  output nbp_pkg::sts_t         sts,
  output logic                  out_valid,
  output nbp_pkg::out_rsp_t     out_data,
  input  wire logic             out_stall
);
  import nbp_pkg::*;

  `include "nested_block_profiler_core_assert.svh"

  localparam int SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int DW  = $clog2(NEST_DEPTH + 1);

  in_req_t           req_r;
  logic [1:0]        status_r;
  logic [UNIT_W-1:0] clr_addr_r;
  logic [DW-1:0]     depth_r;
  logic [UNIT_W-1:0] pop_unit_r;
  logic [UNIT_W-1:0] par_unit_r;
  logic [63:0]       saved_r;
  logic [63:0]       elapsed_r;
  logic [UNIT_W-1:0] rep_unit_r;
  tbl_entry_t        rep_r;
  logic              out_valid_r;
  out_rsp_t          out_data_r;

  tbl_entry_t        tbl_mem [UNIT_COUNT];
  tbl_entry_t        tbl_q;
  frame_t            stk_mem [NEST_DEPTH];
  frame_t            stk_q;

  logic [UNIT_W-1:0] tbl_raddr;
  logic [UNIT_W-1:0] tbl_addr;
  logic              tbl_we;
  tbl_entry_t        tbl_wdata;
  tbl_entry_t        pop_new;
  tbl_entry_t        par_new;
  logic [DW-1:0]     stk_addr_full;
  logic [SAW-1:0]    stk_addr;
  logic              out_free;

  always_comb begin
    case (cmd.tbl_sel)
      SEL_REQ:  tbl_raddr = req_r.unit_id;
      SEL_ZERO: tbl_raddr = '0;
      SEL_POP:  tbl_raddr = pop_unit_r;
      SEL_PAR:  tbl_raddr = par_unit_r;
      default:  tbl_raddr = '0;
    endcase
  end

  always_comb begin
    pop_new.hits = tbl_q.hits + 32'd1;
    pop_new.incl = saved_r + elapsed_r;
    pop_new.excl = tbl_q.excl + elapsed_r;
    par_new      = tbl_q;
    par_new.excl = tbl_q.excl - elapsed_r;
  end

  always_comb begin
    tbl_we    = cmd.clr_en | cmd.wr_pop | cmd.wr_par;
    tbl_wdata = '0;
    tbl_addr  = tbl_raddr;
    if (cmd.clr_en) begin
      tbl_addr = clr_addr_r;
    end else if (cmd.wr_pop) begin
      tbl_addr  = pop_unit_r;
      tbl_wdata = pop_new;
    end else if (cmd.wr_par) begin
      tbl_addr  = par_unit_r;
      tbl_wdata = par_new;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end else if (cmd.tbl_rd) begin
      tbl_q <= tbl_mem[tbl_addr];
    end
  end

  always_comb begin
    if (cmd.stk_rd_top) begin
      stk_addr_full = depth_r - DW'(1);
    end else if (cmd.stk_rd_par) begin
      stk_addr_full = depth_r - DW'(2);
    end else begin
      stk_addr_full = depth_r;
    end
  end

  assign stk_addr = stk_addr_full[SAW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[stk_addr] <= '{unit: req_r.unit_id, start: req_r.timestamp,
                             saved: tbl_q.incl};
    end else if (cmd.stk_rd_top || cmd.stk_rd_par) begin
      stk_q <= stk_mem[stk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_addr_r <= clr_addr_r + UNIT_W'(1);
      if (cmd.push) begin
        depth_r <= depth_r + DW'(1);
      end else if (cmd.cap_par) begin
        depth_r <= depth_r - DW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_data;
    if (cmd.set_status) status_r <= cmd.status;
    if (cmd.tbl_rd && cmd.tbl_sel != SEL_PAR) rep_unit_r <= tbl_raddr;
    if (cmd.cap_top) begin
      pop_unit_r <= stk_q.unit;
      saved_r    <= stk_q.saved;
      elapsed_r  <= req_r.timestamp - stk_q.start;
    end
    if (cmd.cap_par) par_unit_r <= (depth_r > DW'(1)) ? stk_q.unit : '0;
    if (cmd.cap_rep) rep_r <= tbl_q;
    if (cmd.wr_pop) rep_r <= pop_new;
    if (cmd.wr_par && par_unit_r == pop_unit_r) rep_r.excl <= par_new.excl;
    if (cmd.load_out) begin
      out_data_r <= '{status: status_r, result_unit: rep_unit_r, hit_count: rep_r.hits,
                      inclusive_time: rep_r.incl, exclusive_time: rep_r.excl};
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.kind        = req_r.kind;
    sts.unit_zero   = (req_r.unit_id == '0);
    sts.stack_full  = (depth_r == DW'(NEST_DEPTH));
    sts.stack_empty = (depth_r == '0);
    sts.clear_last  = (clr_addr_r == UNIT_W'(UNIT_COUNT - 1));
    sts.out_free    = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `NBP_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= DW'(NEST_DEPTH), "frame depth overran")
  `NBP_ASSERT_NOW(a_push_room, cmd.push, !sts.stack_full, "push on a full stack")
  `NBP_ASSERT_NEXT(a_push_step, cmd.push, depth_r == $past(depth_r) + DW'(1), "push lost")
  `NBP_ASSERT_NOW(a_out_room, cmd.load_out, out_free, "result register overwritten")

endmodule

`default_nettype wire

// File: rtl/core/nested_block_profiler_core.sv
// ----------------------------------------------------------------------------
// nested_block_profiler_core
// Profiler for nested timed regions with per-unit hit, inclusive and
// exclusive time counters.
//
// Input channel in_valid/in_stall/in_data carries one request: enter a region,
// exit the innermost region, or read a unit entry. Result channel
// out_valid/out_stall/out_data returns one result per request.
// The block takes one request at a time. An enter or read steps through the
// states S_DECODE, S_TWAIT and S_REPORT. An exit on a non-empty stack steps
// through S_DECODE, S_XTOP, S_XPAR, S_XUPDPOP, S_XRDPAR, S_XUPDPAR and S_REPORT,
// since the unit table is single-port with registered reads: such an exit reads
// and writes back the popped unit and then its parent.
// After reset the unit table is swept to zero, one entry a cycle, over
// all UNIT_COUNT (4096) entries while in_stall stays high. The frame depth resets
// to zero. A result waits in the output register while out_stall is high;
// the next request is accepted meanwhile, and its result is held back until
// the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_block_profiler_core #(
  parameter int NEST_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nbp_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nbp_pkg::out_rsp_t      out_data
);
  import nbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nbp_dp #(
    .NEST_DEPTH (NEST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire
